// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers used by the RTL; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked only outside reset
`define CHK_ON(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// checked on every edge, reset included
`define CHK_ALL(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define CHK_ON(lbl, clk, rst, prop)
`define CHK_ALL(lbl, clk, prop)
`endif

`endif

// ----- src/hbq_pkg.sv -----
// ----------------------------------------------------------------------------
// hbq_pkg
// Types and constants of the binary min-heap queue.
// ----------------------------------------------------------------------------
package hbq_pkg;

  localparam int KEY_BITS  = 8;
  localparam int ID_BITS   = 16;
  localparam int DEPTH     = 64;
  localparam int ADDR_BITS = 6;
  localparam int CNT_BITS  = 7;
  localparam int CFG_BITS  = 7;

  localparam logic       CMD_INSERT  = 1'b0;
  localparam logic       CMD_EXTRACT = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                cmd;
    logic [KEY_BITS-1:0] in_priority;
    logic [ID_BITS-1:0]  in_payload;
  } in_req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [KEY_BITS-1:0] out_priority;
    logic [ID_BITS-1:0]  out_payload;
    logic                top_valid;
    logic [KEY_BITS-1:0] top_priority;
    logic [CNT_BITS-1:0] count;
  } out_rsp_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [ID_BITS-1:0]  id;
  } entry_t;

endpackage

// ----- src/hbq_ram.sv -----
// ----------------------------------------------------------------------------
// hbq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hbq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/binary_min_heap_queue.sv -----
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Min-heap priority queue of (key, id) records held in one synchronous RAM.
// ----------------------------------------------------------------------------
//  channel   signals                       direction
//  request   in_valid / in_ready / in_data  in
//  response  out_valid / out_ready / out_data  out
//  config    cfg_we / cfg_wdata             in (capacity_limit)
//
//  One request at a time; the steps below run from the accept to the response.
//  Insert: read the parent, then compare and write, once per level climbed.
//  Extract: read the root, then the last entry; per level read the left
//  and, if present, the right child (two child reads on the single RAM read
//  port), then write. Refused: straight to done, then idle before the next accept.
//  Reset clears the count and the capacity (to 64); the RAM is not cleared,
//  only entries below the count are read. A held response keeps the block
//  in its done state with in_ready low until the output register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module binary_min_heap_queue
  import hbq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_req_t             in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_rsp_t            out_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_UP_CHK, S_UP_CMP, S_DN_ROOT, S_DN_LAST,
    S_DN_CHK, S_DN_L, S_DN_R, S_DONE
  } state_t;

  state_t               state;
  logic [CNT_BITS-1:0]  cnt;        // stored entries
  logic [CFG_BITS-1:0]  cap;        // capacity_limit register
  logic [ADDR_BITS-1:0] pos;        // hole position during a sift
  entry_t               x;          // record being moved
  entry_t               lft;        // left child, held for the right compare
  logic                 lsm;        // left child beats x
  entry_t               oent;       // extracted record
  logic [1:0]           status;
  logic [KEY_BITS-1:0]  root_key;   // copy of entry 0's key
  logic                 rsp_load;   // response enters the output register

  // RAM ports
  logic                 we;
  logic [ADDR_BITS-1:0] waddr;
  logic [ADDR_BITS-1:0] raddr;
  entry_t               wdata;
  entry_t               rd;

  hbq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd)
  );

  // heap index arithmetic
  logic [ADDR_BITS-1:0] parent;
  logic [CNT_BITS-1:0]  lc;
  logic [CNT_BITS:0]    rc;
  logic                 lc_in, rc_in, l_small, r_small;
  logic [CNT_BITS-1:0]  limit;

  assign parent  = (pos - 1'b1) >> 1;
  assign lc      = {pos, 1'b1};
  assign rc      = {1'b0, pos, 1'b0} + (CNT_BITS+1)'(2);
  assign lc_in   = lc < cnt;
  assign rc_in   = rc < {1'b0, cnt};
  assign l_small = rd.key < x.key;                          // valid in S_DN_L
  assign r_small = rd.key < (lsm ? lft.key : x.key);        // valid in S_DN_R
  assign limit   = (cap > CNT_BITS'(DEPTH)) ? CNT_BITS'(DEPTH) : cap;
  assign in_ready = (state == S_IDLE);
  assign rsp_load = (state == S_DONE) && (!out_valid || out_ready);

  // RAM control: hole-style sifts write each level once
  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = x;
    raddr = '0;              // idle: root read for a possible extract
    unique case (state)
      S_UP_CHK: begin
        if (pos == '0) we = 1'b1;
        else raddr = parent;
      end
      S_UP_CMP: begin
        we    = 1'b1;
        wdata = (rd.key > x.key) ? rd : x;
      end
      S_DN_ROOT: raddr = ADDR_BITS'(cnt - 1'b1);
      S_DN_CHK: begin
        if (!lc_in) we = 1'b1;
        else raddr = lc[ADDR_BITS-1:0];
      end
      S_DN_L: begin
        if (rc_in) begin
          raddr = rc[ADDR_BITS-1:0];
        end else begin
          we    = 1'b1;
          wdata = l_small ? rd : x;
        end
      end
      S_DN_R: begin
        we    = 1'b1;
        wdata = r_small ? rd : (lsm ? lft : x);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      cap       <= CFG_BITS'(64);
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) cap <= cfg_wdata;
      if (we && waddr == '0) root_key <= wdata.key;
      if (rsp_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            x      <= '{key: in_data.in_priority, id: in_data.in_payload};
            oent   <= '0;
            status <= ST_OK;
            if (in_data.cmd == CMD_INSERT) begin
              if (cnt >= limit) begin
                status <= ST_FULL;
                state  <= S_DONE;
              end else begin
                pos   <= cnt[ADDR_BITS-1:0];
                cnt   <= cnt + 1'b1;
                state <= S_UP_CHK;
              end
            end else begin
              if (cnt == '0) begin
                status <= ST_EMPTY;
                state  <= S_DONE;
              end else begin
                state <= S_DN_ROOT;
              end
            end
          end
        end
        S_UP_CHK: state <= (pos == '0) ? S_DONE : S_UP_CMP;
        S_UP_CMP: begin
          if (rd.key > x.key) begin
            pos   <= parent;
            state <= S_UP_CHK;
          end else begin
            state <= S_DONE;
          end
        end
        S_DN_ROOT: begin
          oent  <= rd;
          state <= S_DN_LAST;
        end
        S_DN_LAST: begin
          x     <= rd;
          cnt   <= cnt - 1'b1;
          pos   <= '0;
          state <= S_DN_CHK;
        end
        S_DN_CHK: state <= lc_in ? S_DN_L : S_DONE;
        S_DN_L: begin
          lft <= rd;
          lsm <= l_small;
          if (rc_in) begin
            state <= S_DN_R;
          end else if (l_small) begin
            pos   <= lc[ADDR_BITS-1:0];
            state <= S_DN_CHK;
          end else begin
            state <= S_DONE;
          end
        end
        S_DN_R: begin
          if (r_small) begin
            pos   <= rc[ADDR_BITS-1:0];
            state <= S_DN_CHK;
          end else if (lsm) begin
            pos   <= lc[ADDR_BITS-1:0];
            state <= S_DN_CHK;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp_load) begin
            out_data.status       <= status;
            out_data.out_priority <= oent.key;
            out_data.out_payload  <= oent.id;
            out_data.top_valid    <= (cnt != '0);
            out_data.top_priority <= (cnt != '0) ? root_key : '0;
            out_data.count        <= cnt;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // count never passes the RAM depth
  `CHK_ON(a_cnt_range, clk, rst, cnt <= CNT_BITS'(DEPTH))
  // one request in flight: no accept right after an accept
  `CHK_ON(a_one_req, clk, rst, (in_valid && in_ready) |=> !in_ready)
  // reset leaves an empty heap and no response
  `CHK_ALL(a_rst_clear, clk, $past(rst) |-> (cnt == '0 && !out_valid))
  // a response reports nonempty exactly when its count is nonzero
  `CHK_ON(a_top_cnt, clk, rst,
          out_valid |-> (out_data.top_valid == (out_data.count != '0)))

endmodule

// ----- test/tb_binary_min_heap_queue.sv -----
// ----------------------------------------------------------------------------
// tb_binary_min_heap_queue
// Self-checking bench for the min-heap queue: a software heap predicts each
// response, random bursts and stalls exercise the handshakes.
// ----------------------------------------------------------------------------
module tb_binary_min_heap_queue;
  import hbq_pkg::*;

  // Software copy of the heap; predicts one response per accepted request.
  class heap_scoreboard;
    logic [KEY_BITS-1:0] keys[DEPTH];
    logic [ID_BITS-1:0]  ids[DEPTH];
    int                  used;
    int                  cap_limit;
    out_rsp_t            pending[$];
    int                  mismatches;

    function void clear();
      used       = 0;
      cap_limit  = 64;
      mismatches = 0;
      pending.delete();
    endfunction

    function void swap_slots(int a, int b);
      logic [KEY_BITS-1:0] k;
      logic [ID_BITS-1:0]  d;
      k = keys[a]; d = ids[a];
      keys[a] = keys[b]; ids[a] = ids[b];
      keys[b] = k; ids[b] = d;
    endfunction

    function void note_request(in_req_t req);
      out_rsp_t rsp;
      int       lim;
      int       pos;
      int       best;
      int       up;
      lim = (cap_limit > DEPTH) ? DEPTH : cap_limit;
      rsp = '0;
      if (req.cmd == CMD_INSERT) begin
        if (used >= lim) begin
          rsp.status = ST_FULL;
        end else begin
          pos = used;
          keys[pos] = req.in_priority;
          ids[pos]  = req.in_payload;
          used++;
          // climb while parent strictly larger
          while (pos != 0) begin
            up = (pos - 1) / 2;
            if (!(keys[up] > keys[pos])) break;
            swap_slots(pos, up);
            pos = up;
          end
        end
      end else begin
        if (used == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          rsp.out_priority = keys[0];
          rsp.out_payload  = ids[0];
          keys[0] = keys[used-1];
          ids[0]  = ids[used-1];
          used--;
          pos = 0;
          // descend; left wins ties, equal keys never swap
          forever begin
            best = pos;
            if (2*pos+1 < used && keys[2*pos+1] < keys[best]) best = 2*pos+1;
            if (2*pos+2 < used && keys[2*pos+2] < keys[best]) best = 2*pos+2;
            if (best == pos) break;
            swap_slots(pos, best);
            pos = best;
          end
        end
      end
      rsp.top_valid    = (used != 0);
      rsp.top_priority = (used != 0) ? keys[0] : '0;
      rsp.count        = used[CNT_BITS-1:0];
      pending.push_back(rsp);
    endfunction

    function void check_response(out_rsp_t got);
      out_rsp_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.out_priority !== want.out_priority ||
          got.out_payload !== want.out_payload || got.top_valid !== want.top_valid ||
          got.top_priority !== want.top_priority || got.count !== want.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CFG_BITS-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_req_t             in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_rsp_t            out_data;

  heap_scoreboard      heap_sb;
  bit                  hold_off = 1'b0;  // long receiver stall request
  bit                  stim_done = 1'b0;

  always #1 clk = ~clk;

  binary_min_heap_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) heap_sb.note_request(in_data);
      if (out_valid && out_ready) heap_sb.check_response(out_data);
    end
  end

  // Receiver: ready pattern of its own, plus a long hold-off when asked.
  initial begin : receiver
    int mode;
    int n;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      mode = $urandom_range(0, 3);
      n = $urandom_range(1, 40);
      repeat (n) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 5) == 0);
        endcase
        @(negedge clk);
      end
    end
  end

  // One request: hold valid until accepted; called at a falling edge.
  task automatic send_request(input logic cmd, input logic [KEY_BITS-1:0] pri,
                              input logic [ID_BITS-1:0] pid);
    in_valid <= 1'b1;
    in_data  <= '{cmd: cmd, in_priority: pri, in_payload: pid};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic idle_cycles(input int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Wait for every response, then the block's latency, before a register write.
  task automatic drain_then_write(input int value);
    idle_cycles(1);
    while (heap_sb.pending.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[CFG_BITS-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    heap_sb.cap_limit = value;
  endtask

  // Random phase: bursts with gaps; insert bias set by ins_pct.
  task automatic random_phase(input int n_items, input int ins_pct);
    int sent;
    int burst;
    logic [KEY_BITS-1:0] pri;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        case ($urandom_range(0, 5))
          0: pri = '0;
          1: pri = '1;
          2: pri = KEY_BITS'($urandom_range(0, 3));  // many equal keys
          default: pri = KEY_BITS'($urandom);
        endcase
        send_request(($urandom_range(0, 99) >= ins_pct) ? CMD_EXTRACT : CMD_INSERT,
                     pri, ID_BITS'($urandom));
        sent++;
      end
      if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 30));
    end
  endtask

  initial begin : stimulus
    heap_sb = new();
    heap_sb.clear();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty extract, extremes, ties, full at small capacity.
    send_request(CMD_EXTRACT, 8'hff, 16'hffff);
    send_request(CMD_INSERT, 8'hff, 16'hffff);
    send_request(CMD_INSERT, 8'h00, 16'h0000);
    send_request(CMD_INSERT, 8'h05, 16'h1111);
    send_request(CMD_INSERT, 8'h05, 16'h2222);
    send_request(CMD_INSERT, 8'h05, 16'h3333);
    send_request(CMD_INSERT, 8'haa, 16'h5555);
    send_request(CMD_INSERT, 8'h55, 16'haaaa);
    repeat (8) send_request(CMD_EXTRACT, '0, '0);
    drain_then_write(2);
    repeat (4) send_request(CMD_INSERT, KEY_BITS'($urandom), ID_BITS'($urandom));
    drain_then_write(1);           // lowered below count
    send_request(CMD_INSERT, 8'h01, 16'h0001);
    send_request(CMD_EXTRACT, '0, '0);
    send_request(CMD_EXTRACT, '0, '0);
    drain_then_write(0);           // every insert refused
    send_request(CMD_INSERT, 8'h10, 16'h0010);
    send_request(CMD_EXTRACT, '0, '0);

    // Above depth acts as depth; fill past full.
    drain_then_write(127);
    random_phase(120, 80);
    // Sender offers while receiver holds off, so the block stalls its input.
    hold_off = 1'b1;
    random_phase(40, 50);
    random_phase(200, 50);
    drain_then_write(64);
    random_phase(300, 60);
    random_phase(250, 40);
    drain_then_write($urandom_range(3, 12));
    random_phase(200, 55);
    drain_then_write(64);
    random_phase(200, 65);
    random_phase(60, 0);           // drain through empty
    idle_cycles(1);
    stim_done = 1'b1;
  end

  // Final check.
  initial begin : finisher
    wait (stim_done);
    while (heap_sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (heap_sb.mismatches == 0 && heap_sb.pending.size() == 0) begin
      $display("** binary_min_heap_queue: PASSED **");
    end else begin
      $display("** binary_min_heap_queue: FAILED **");
    end
    $finish;
  end

  // Watchdog.
  initial begin : watchdog
    #2000000;
    $display("** binary_min_heap_queue: FAILED **");
    $finish;
  end

endmodule
